/* rtl/core/utrd_pkg.sv */
`default_nettype none

package utrd_pkg;

  // default width of the value path
  localparam int unsigned DEF_VALUE_WIDTH = 64;
  // width of the value field on the ports
  localparam int unsigned IN_VALUE_W      = 64;
  localparam int unsigned BASE_W          = 5;
  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned SHIFT_W         = 3;

  // dividend bits retired per divider cycle
  localparam int unsigned DIV_BITS        = 8;
  // items held between front and back
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [BASE_W-1:0] MIN_BASE  = 5'd2;
  localparam logic [BASE_W-1:0] MAX_BASE  = 5'd16;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;

  // how the back end extracts digits
  typedef enum logic {
    KIND_POW2,
    KIND_DIV
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // classification of one item, as handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [BASE_W-1:0]   base;
    logic [SHIFT_W-1:0]  shift;
  } cls_t;

  // digit value to upper-case ASCII
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_UPPER_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/utrd_front.sv */
`default_nettype none

module utrd_front #(
  parameter int unsigned VALUE_WIDTH = utrd_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                                  start_i,
  input  wire logic [utrd_pkg::IN_VALUE_W-1:0]       value_i,
  input  wire logic [utrd_pkg::BASE_W-1:0]           base_i,
  input  wire logic                                  full_i,
  output logic                                       push_o,
  output logic [VALUE_WIDTH-1:0]                     value_o,
  output utrd_pkg::cls_t                             cls_o
);

  logic [utrd_pkg::BASE_W-1:0] base_clamped;
  logic                        is_pow2;

  // accept whenever the queue has room
  assign push_o  = start_i & ~full_i;
  assign value_o = value_i[VALUE_WIDTH-1:0];

  // clamp the base into 2..16
  always_comb begin
    if (base_i < utrd_pkg::MIN_BASE) begin
      base_clamped = utrd_pkg::MIN_BASE;
    end else if (base_i > utrd_pkg::MAX_BASE) begin
      base_clamped = utrd_pkg::MAX_BASE;
    end else begin
      base_clamped = base_i;
    end
  end

  // power-of-two bases go through the shifter, the rest through the divider
  assign is_pow2 = ((base_clamped & (base_clamped - 5'd1)) == '0);

  always_comb begin
    cls_o.base = base_clamped;
    cls_o.kind = is_pow2 ? utrd_pkg::KIND_POW2 : utrd_pkg::KIND_DIV;
    case (base_clamped)
      5'd2:    cls_o.shift = 3'd1;
      5'd4:    cls_o.shift = 3'd2;
      5'd8:    cls_o.shift = 3'd3;
      5'd16:   cls_o.shift = 3'd4;
      default: cls_o.shift = 3'd0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/utrd_queue.sv */
`default_nettype none

module utrd_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = utrd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  input  wire logic          pop_i,
  output logic [DW-1:0]      data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q,  count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utrd_back.sv */
`default_nettype none

module utrd_back #(
  parameter int unsigned VALUE_WIDTH = utrd_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             empty_i,
  input  wire logic [VALUE_WIDTH-1:0]           value_i,
  input  wire utrd_pkg::cls_t                   cls_i,
  output logic                                  pop_o,
  output logic                                  valid_o,
  output logic [utrd_pkg::CHAR_W-1:0]           digit_char_o,
  output logic                                  last_o
);

  localparam int unsigned SB    = utrd_pkg::DIV_BITS;
  localparam int unsigned NSTEP = (VALUE_WIDTH + SB - 1) / SB;
  localparam int unsigned WW    = NSTEP * SB;
  localparam int unsigned SC_W  = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned AW    = $clog2(VALUE_WIDTH);
  localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DW    = utrd_pkg::DIGIT_W;
  localparam int unsigned BW    = utrd_pkg::BASE_W;

  utrd_pkg::state_e state_q, state_d;

  logic [WW-1:0]                    work_q;
  logic [DW-1:0]                    rem_q;
  logic [SC_W-1:0]                  step_q;
  logic [CW-1:0]                    cnt_q;
  utrd_pkg::kind_e                  kind_q;
  logic [BW-1:0]                    base_q;
  logic [utrd_pkg::SHIFT_W-1:0]     shift_q;
  logic [AW-1:0]                    rd_idx_q;
  logic [DW-1:0]                    rd_data_q;
  logic                             out_valid_q;
  logic                             out_last_q;

  // digit store, least significant digit at address zero
  logic [DW-1:0]                    digit_mem [VALUE_WIDTH];

  logic [WW-1:0]                    div_work;
  logic [DW-1:0]                    div_rem;
  logic [WW-1:0]                    pow_work;
  logic [DW-1:0]                    pow_digit;
  logic [WW-1:0]                    next_work;
  logic                             digit_done;
  logic                             stop;
  logic                             wr_en;
  logic [DW-1:0]                    wr_data;
  logic                             rd_en;
  logic                             rd_last;

  // one divider cycle: SB restoring steps on a remainder below the base
  always_comb begin
    logic [WW-1:0] w;
    logic [DW-1:0] r;
    logic [BW-1:0] t;
    w = work_q;
    r = rem_q;
    for (int i = 0; i < SB; i++) begin
      t = {r, w[WW-1]};
      w = {w[WW-2:0], 1'b0};
      if (t >= base_q) begin
        t    = t - base_q;
        w[0] = 1'b1;
      end
      r = t[DW-1:0];
    end
    div_work = w;
    div_rem  = r;
  end

  // power-of-two base: mask off the digit, shift it out
  assign pow_digit = work_q[DW-1:0] & (base_q[DW-1:0] - 4'd1);
  assign pow_work  = work_q >> shift_q;

  assign next_work = (kind_q == utrd_pkg::KIND_POW2) ? pow_work : div_work;
  assign stop      = digit_done &&
                     ((next_work == '0) || (cnt_q == CW'(VALUE_WIDTH - 1)));

  // control outputs
  always_comb begin
    pop_o      = 1'b0;
    digit_done = 1'b0;
    wr_en      = 1'b0;
    wr_data    = div_rem;
    rd_en      = 1'b0;
    rd_last    = (rd_idx_q == '0);
    case (state_q)
      utrd_pkg::ST_IDLE: begin
        pop_o = ~empty_i;
      end
      utrd_pkg::ST_DIV: begin
        if (kind_q == utrd_pkg::KIND_POW2) begin
          digit_done = 1'b1;
          wr_data    = pow_digit;
        end else begin
          digit_done = (step_q == SC_W'(NSTEP - 1));
        end
        wr_en = digit_done;
      end
      utrd_pkg::ST_EMIT: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      utrd_pkg::ST_IDLE: if (!empty_i) state_d = utrd_pkg::ST_DIV;
      utrd_pkg::ST_DIV:  if (stop)     state_d = utrd_pkg::ST_EMIT;
      utrd_pkg::ST_EMIT: if (rd_last)  state_d = utrd_pkg::ST_IDLE;
      default:                         state_d = utrd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utrd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= rd_en;
      if (pop_o) begin
        step_q <= '0;
        cnt_q  <= '0;
      end else if (state_q == utrd_pkg::ST_DIV) begin
        if (digit_done) begin
          step_q <= '0;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q  <= WW'(value_i);
      rem_q   <= '0;
      kind_q  <= cls_i.kind;
      base_q  <= cls_i.base;
      shift_q <= cls_i.shift;
    end else if (state_q == utrd_pkg::ST_DIV) begin
      work_q <= next_work;
      rem_q  <= digit_done ? '0 : div_rem;
    end
    // emission walks from the most significant digit down
    if (stop) begin
      rd_idx_q <= cnt_q[AW-1:0];
    end else if (rd_en) begin
      rd_idx_q <= rd_idx_q - 1'b1;
    end
    out_last_q <= rd_last;
  end

  // digit memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_mem[cnt_q[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= digit_mem[rd_idx_q];
    end
  end

  assign valid_o      = out_valid_q;
  assign last_o       = out_valid_q & out_last_q;
  assign digit_char_o = utrd_pkg::digit_ascii(rd_data_q);

endmodule

`default_nettype wire

/* rtl/core/unsigned_to_radix_digits.sv */
// Converts an unsigned value of VALUE_WIDTH bits into its digits in a base
// from 2 to 16 (lower bases count as 2, higher as 16) and sends them out most
// significant first as upper-case ASCII, one digit per cycle on valid_o,
// with last_o on the final digit; zero gives the single digit '0'. An item
// is taken when start is high and busy low; two items can wait while
// one is converted, and busy is high only while that queue is full. The
// results cannot be held off: each digit is shown for exactly one cycle.
// Per item, power-of-two bases take one shift per digit, then one memory
// read per digit; other bases run the divider, which retires 8 dividend
// bits per cycle, for each digit, and then read the digits back through
// the single read port of the digit memory.
`default_nettype none

module unsigned_to_radix_digits #(
  parameter int unsigned VALUE_WIDTH = utrd_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [utrd_pkg::IN_VALUE_W-1:0]   value_i,
  input  wire logic [utrd_pkg::BASE_W-1:0]       base_i,
  output logic                                   valid_o,
  output logic [utrd_pkg::CHAR_W-1:0]            digit_char_o,
  output logic                                   last_o
);

  localparam int unsigned QW = VALUE_WIDTH + $bits(utrd_pkg::cls_t);

  logic                   push, pop, full, empty;
  logic [VALUE_WIDTH-1:0] front_value;
  utrd_pkg::cls_t         front_cls;
  logic [QW-1:0]          q_data;
  utrd_pkg::cls_t         back_cls;

  utrd_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .start_i (start),
    .value_i (value_i),
    .base_i  (base_i),
    .full_i  (full),
    .push_o  (push),
    .value_o (front_value),
    .cls_o   (front_cls)
  );

  utrd_queue #(
    .DW    (QW),
    .DEPTH (utrd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_cls, front_value}),
    .pop_i   (pop),
    .data_o  (q_data),
    .full_o  (full),
    .empty_o (empty)
  );

  assign back_cls = q_data[QW-1:VALUE_WIDTH];

  utrd_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .value_i      (q_data[VALUE_WIDTH-1:0]),
    .cls_i        (back_cls),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  assign busy = full;

endmodule

`default_nettype wire

/* rtl/core/utrd_checker.sv */
`default_nettype none

module utrd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid_o,
  input wire logic [6:0] digit_char_o,
  input wire logic       last_o
);

  // digits of one item come out in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("digit stream broken before last digit");

  // the queue only fills on a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // room frees up only once the item in work has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(valid_o && last_o))
    else $error("busy fell without a final digit");

  // every digit is a legal character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                 (digit_char_o >= 7'd65 && digit_char_o <= 7'd70)))
    else $error("digit character out of range");

endmodule

bind unsigned_to_radix_digits utrd_checker u_chk (.*);

`default_nettype wire
